// ===== src/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// shared types and constants of the sorted score table block
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned SCORE_W     = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned FOUND_W     = 4;
  localparam int unsigned CMP_W       = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int unsigned POS_CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam logic [CFG_W-1:0] RESET_IN_USE = CFG_W'(12);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_SORT   = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_MISS    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT_START,
    S_SORT_LOAD,
    S_SORT_RUN,
    S_SORT_LAST,
    S_SRCH_PROBE,
    S_SRCH_CMP,
    S_DONE
  } state_e;

endpackage

// ===== src/sorted_table_search_update_top.sv =====
// ----------------------------------------------------------------------------
// sorted_table_search_update_top
// score table in one synchronous memory with write, bubble sort and
// binary search, one request at a time
// ----------------------------------------------------------------------------
// throughput: one request at a time, limited by the single read and single
//   write port of the table memory; the next request enters once the
//   result sits in the output register
// reset: table reads as zero through per-entry valid bits cleared at once,
//   entries_in_use returns to 12, no clearing pass
module sorted_table_search_update_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_wr_en_i,
  input  logic [sts_pkg::CFG_W-1:0]             cfg_wr_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [sts_pkg::OP_W-1:0]              op_i,
  input  logic [sts_pkg::POS_W-1:0]             index_i,
  input  logic signed [sts_pkg::SCORE_W-1:0]    value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [sts_pkg::STATUS_W-1:0]          status_o,
  output logic [sts_pkg::FOUND_W-1:0]           found_index_o
);

  sts_pkg::state_e state_q, state_d;

  logic [sts_pkg::CFG_W-1:0]     in_use_q;
  logic                          out_valid_q, out_valid_d;
  sts_pkg::status_e              out_status_q;
  logic [sts_pkg::FOUND_W-1:0]   out_found_q;
  sts_pkg::status_e              res_status_q, res_status_d;
  logic [sts_pkg::FOUND_W-1:0]   res_found_q, res_found_d;
  logic [sts_pkg::SCORE_W-1:0]   val_q, val_d;
  logic [sts_pkg::SCORE_W-1:0]   carry_q, carry_d;
  logic [sts_pkg::IDX_W-1:0]     cur_q, cur_d;
  logic [sts_pkg::IDX_W-1:0]     pass_end_q, pass_end_d;
  logic [sts_pkg::IDX_W-1:0]     mid_q, mid_d;
  logic [sts_pkg::CNT_W-1:0]     lo_q, lo_d;
  logic [sts_pkg::CNT_W-1:0]     ub_q, ub_d;

  // table memory and its valid bits
  logic [sts_pkg::SCORE_W-1:0]     mem_q [sts_pkg::MAX_ENTRIES];
  logic [sts_pkg::MAX_ENTRIES-1:0] ent_vld_q;
  logic                            mem_we, mem_re;
  logic [sts_pkg::IDX_W-1:0]       mem_waddr, mem_raddr;
  logic [sts_pkg::SCORE_W-1:0]     mem_wdata;
  logic [sts_pkg::SCORE_W-1:0]     rdata_q;
  logic                            rvld_q;
  logic [sts_pkg::SCORE_W-1:0]     rd_val;

  logic                          in_acc;
  logic                          out_load;
  logic [sts_pkg::CNT_W-1:0]     used_cnt;
  logic                          pos_ok;
  logic                          rd_less;
  logic [sts_pkg::CNT_W:0]       mid_sum;
  sts_pkg::op_e                  op;

  assign op       = sts_pkg::op_e'(op_i);
  assign in_stall_o = (state_q != sts_pkg::S_IDLE);
  assign in_acc   = in_valid_i & ~in_stall_o;
  assign out_load = (state_q == sts_pkg::S_DONE) & (~out_valid_q | ~out_stall_i);

  // entries_in_use clamped to the table depth
  assign used_cnt = (sts_pkg::CMP_W'(in_use_q) > sts_pkg::CMP_W'(sts_pkg::MAX_ENTRIES)) ?
                    sts_pkg::CNT_W'(sts_pkg::MAX_ENTRIES) : sts_pkg::CNT_W'(in_use_q);
  assign pos_ok   = sts_pkg::POS_CMP_W'(index_i) < sts_pkg::POS_CMP_W'(used_cnt);

  // never-written entries read as zero
  assign rd_val   = rvld_q ? rdata_q : '0;
  assign rd_less  = $signed(rd_val) < $signed(carry_q);
  assign mid_sum  = {1'b0, lo_q} + {1'b0, ub_q} - 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sts_pkg::S_IDLE: begin
        if (in_acc) begin
          case (op)
            sts_pkg::OP_SORT: begin
              state_d = (used_cnt > sts_pkg::CNT_W'(1)) ? sts_pkg::S_SORT_START
                                                        : sts_pkg::S_DONE;
            end
            sts_pkg::OP_SEARCH: state_d = sts_pkg::S_SRCH_PROBE;
            default:            state_d = sts_pkg::S_DONE;
          endcase
        end
      end
      sts_pkg::S_SORT_START: state_d = sts_pkg::S_SORT_LOAD;
      sts_pkg::S_SORT_LOAD:  state_d = sts_pkg::S_SORT_RUN;
      sts_pkg::S_SORT_RUN: begin
        if (cur_q == pass_end_q) begin
          state_d = sts_pkg::S_SORT_LAST;
        end
      end
      sts_pkg::S_SORT_LAST: begin
        state_d = (pass_end_q == sts_pkg::IDX_W'(1)) ? sts_pkg::S_DONE
                                                     : sts_pkg::S_SORT_START;
      end
      sts_pkg::S_SRCH_PROBE: begin
        state_d = (lo_q < ub_q) ? sts_pkg::S_SRCH_CMP : sts_pkg::S_DONE;
      end
      sts_pkg::S_SRCH_CMP: begin
        state_d = (rd_val == val_q) ? sts_pkg::S_DONE : sts_pkg::S_SRCH_PROBE;
      end
      sts_pkg::S_DONE: begin
        if (out_load) begin
          state_d = sts_pkg::S_IDLE;
        end
      end
      default: state_d = sts_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    val_d        = val_q;
    carry_d      = carry_q;
    cur_d        = cur_q;
    pass_end_d   = pass_end_q;
    mid_d        = mid_q;
    lo_d         = lo_q;
    ub_d         = ub_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    case (state_q)
      sts_pkg::S_IDLE: begin
        if (in_acc) begin
          val_d        = value_i;
          res_found_d  = '0;
          res_status_d = sts_pkg::ST_OK;
          lo_d         = '0;
          ub_d         = used_cnt;
          pass_end_d   = sts_pkg::IDX_W'(used_cnt - 1'b1);
          case (op)
            sts_pkg::OP_WRITE: begin
              if (pos_ok) begin
                mem_we    = 1'b1;
                mem_waddr = sts_pkg::IDX_W'(index_i);
                mem_wdata = value_i;
              end else begin
                res_status_d = sts_pkg::ST_BAD_POS;
              end
            end
            sts_pkg::OP_SEARCH: res_status_d = sts_pkg::ST_MISS;
            default: ;
          endcase
        end
      end
      sts_pkg::S_SORT_START: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        cur_d     = '0;
      end
      sts_pkg::S_SORT_LOAD: begin
        carry_d   = rd_val;
        mem_re    = 1'b1;
        mem_raddr = sts_pkg::IDX_W'(1);
        cur_d     = sts_pkg::IDX_W'(1);
      end
      sts_pkg::S_SORT_RUN: begin
        // smaller one stays behind, larger one bubbles on
        mem_we    = 1'b1;
        mem_waddr = cur_q - 1'b1;
        mem_wdata = rd_less ? rd_val : carry_q;
        carry_d   = rd_less ? carry_q : rd_val;
        if (cur_q != pass_end_q) begin
          mem_re    = 1'b1;
          mem_raddr = cur_q + 1'b1;
          cur_d     = cur_q + 1'b1;
        end
      end
      sts_pkg::S_SORT_LAST: begin
        mem_we     = 1'b1;
        mem_waddr  = pass_end_q;
        mem_wdata  = carry_q;
        pass_end_d = pass_end_q - 1'b1;
      end
      sts_pkg::S_SRCH_PROBE: begin
        mid_d     = sts_pkg::IDX_W'(mid_sum >> 1);
        mem_re    = lo_q < ub_q;
        mem_raddr = sts_pkg::IDX_W'(mid_sum >> 1);
      end
      sts_pkg::S_SRCH_CMP: begin
        if (rd_val == val_q) begin
          res_status_d = sts_pkg::ST_OK;
          res_found_d  = sts_pkg::FOUND_W'(mid_q);
        end else if ($signed(rd_val) < $signed(val_q)) begin
          lo_d = sts_pkg::CNT_W'(mid_q) + 1'b1;
        end else begin
          ub_d = sts_pkg::CNT_W'(mid_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = (out_valid_q & out_stall_i) | out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sts_pkg::S_IDLE;
      in_use_q    <= sts_pkg::RESET_IN_USE;
      out_valid_q <= 1'b0;
      ent_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr_en_i) begin
        in_use_q <= cfg_wr_data_i;
      end
      if (mem_we) begin
        ent_vld_q[mem_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    val_q        <= val_d;
    carry_q      <= carry_d;
    cur_q        <= cur_d;
    pass_end_q   <= pass_end_d;
    mid_q        <= mid_d;
    lo_q         <= lo_d;
    ub_q         <= ub_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
    end
  end

  // single-port-read, single-port-write table, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
      rvld_q  <= ent_vld_q[mem_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_index_o = out_found_q;

endmodule
